### rtl/core/uart_line_buffer_unit_defines.svh
// Assertion macros shared by the line buffer checks.
`ifndef UART_LINE_BUFFER_UNIT_DEFINES_SVH
`define UART_LINE_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define ULB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line buffer check failed");

// Next-cycle implication, ignored while in reset.
`define ULB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line buffer check failed");

`endif

### rtl/core/ulb_pkg.sv
`timescale 1ns / 1ps
package ulb_pkg;

  localparam int LINE_DEPTH_DEF = 16;
  localparam int MAX_RUN        = 16;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    MODE_RX      = 2'd0,
    MODE_TX_DONE = 2'd1,
    MODE_LOAD    = 2'd2,
    MODE_GET     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RX   = 2'd1,
    ST_DONE = 2'd2,
    ST_TX   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_READ = 2'd1,
    B_EMIT = 2'd2
  } back_state_t;

  // Classified request as it sits in the queue
  typedef struct packed {
    mode_t      mode;
    logic [7:0] data;
    logic       last;
    logic       term;
  } op_t;

  // One result item
  typedef struct packed {
    status_t    status;
    logic       rx_enabled;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       accepted;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_last;
  } result_t;

endpackage

### rtl/core/ulb_front.sv
`timescale 1ns / 1ps
module ulb_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_mode,
  input  logic [7:0]       in_data,
  input  logic             in_last,
  output logic             q_valid,
  output ulb_pkg::op_t     q_op,
  input  logic             q_pop
);

  ulb_pkg::op_t ent_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         push;
  ulb_pkg::op_t op_in;

  // classify the incoming request
  always_comb begin
    op_in.mode = ulb_pkg::mode_t'(in_mode);
    op_in.data = in_data;
    op_in.last = in_last;
    op_in.term = (in_data == ulb_pkg::CH_CR) || (in_data == ulb_pkg::CH_LF) ||
                 (in_data == ulb_pkg::CH_NUL);
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_op     = ent_r[rd_ptr_r];

  // two-entry queue pointers
  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

### rtl/core/ulb_back.sv
`timescale 1ns / 1ps
module ulb_back #(
  parameter int LINE_DEPTH = ulb_pkg::LINE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ulb_pkg::op_t      q_op,
  output logic              q_pop,
  output logic              res_valid,
  output ulb_pkg::result_t  res,
  input  logic              out_stall
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int PW = $clog2(LINE_DEPTH + 1);

  logic [7:0]             line_mem_r [LINE_DEPTH];
  logic [7:0]             rd_data_r;

  ulb_pkg::back_state_t   bstate_r, bstate_nxt;
  ulb_pkg::status_t       stat_r, stat_nxt;
  logic                   rxon_r, rxon_nxt;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic [PW-1:0]          lc_r, lc_nxt;
  logic [AW-1:0]          rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]          last_addr_r, last_addr_nxt;
  logic                   run_r, run_nxt;
  logic                   acc_r, acc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ulb_pkg::result_t       out_res_r, out_res_nxt;

  // decoded effect of the request at the head of the queue
  ulb_pkg::status_t       ex_stat;
  logic                   ex_rxon;
  logic [PW-1:0]          ex_pos;
  logic [PW-1:0]          ex_lc;
  logic                   ex_wr;
  logic [AW-1:0]          ex_wr_addr;
  logic                   ex_acc;
  logic                   ex_read;
  logic                   ex_run;
  logic [AW-1:0]          ex_rd_addr;
  logic [AW-1:0]          ex_last_addr;
  logic [PW-1:0]          pos_inc;

  logic                   slot_free;
  logic                   go;
  logic                   emit_done;
  logic                   run_end;
  logic                   rd_en;

  assign slot_free = !out_valid_r || !out_stall;
  assign go        = (bstate_r == ulb_pkg::B_IDLE) && q_valid && slot_free;
  assign emit_done = (bstate_r == ulb_pkg::B_EMIT) && slot_free;
  assign run_end   = !run_r || (rd_addr_r == last_addr_r);
  assign pos_inc   = pos_r + 1'b1;

  // request execution against the line state
  always_comb begin
    ex_stat      = stat_r;
    ex_rxon      = rxon_r;
    ex_pos       = pos_r;
    ex_lc        = lc_r;
    ex_wr        = 1'b0;
    ex_wr_addr   = '0;
    ex_acc       = 1'b0;
    ex_read      = 1'b0;
    ex_run       = 1'b0;
    ex_rd_addr   = '0;
    ex_last_addr = '0;
    case (q_op.mode)
      ulb_pkg::MODE_RX: begin
        if (rxon_r) begin
          case (stat_r)
            ulb_pkg::ST_IDLE: begin
              if (!q_op.term) begin
                ex_lc      = '0;
                ex_wr      = 1'b1;
                ex_wr_addr = '0;
                ex_pos     = PW'(1);
                ex_stat    = ulb_pkg::ST_RX;
              end
            end
            ulb_pkg::ST_RX: begin
              if (!q_op.term && (pos_r < PW'(LINE_DEPTH))) begin
                ex_wr      = 1'b1;
                ex_wr_addr = AW'(pos_r);
                ex_pos     = pos_inc;
              end else begin
                ex_stat = ulb_pkg::ST_DONE;
                ex_rxon = 1'b0;
              end
            end
            default: begin
              ex_rxon = 1'b0;
            end
          endcase
        end
      end
      ulb_pkg::MODE_TX_DONE: begin
        if (stat_r == ulb_pkg::ST_TX) begin
          if (pos_inc < lc_r) begin
            ex_pos     = pos_inc;
            ex_read    = 1'b1;
            ex_rd_addr = AW'(pos_inc);
          end else begin
            ex_stat = ulb_pkg::ST_IDLE;
            ex_rxon = 1'b1;
            ex_lc   = '0;
            ex_pos  = '0;
          end
        end
      end
      ulb_pkg::MODE_LOAD: begin
        // refused outside idle, and an empty string is refused
        if ((stat_r == ulb_pkg::ST_IDLE) &&
            !((q_op.data == ulb_pkg::CH_NUL) && (lc_r == '0))) begin
          ex_acc = 1'b1;
          if (q_op.data != ulb_pkg::CH_NUL) begin
            if (lc_r < PW'(LINE_DEPTH)) begin
              ex_wr      = 1'b1;
              ex_wr_addr = AW'(lc_r);
              ex_lc      = lc_r + 1'b1;
            end
          end
          if ((q_op.data == ulb_pkg::CH_NUL) || q_op.last) begin
            ex_stat    = ulb_pkg::ST_TX;
            ex_rxon    = 1'b0;
            ex_pos     = '0;
            ex_read    = 1'b1;
            ex_rd_addr = '0;
          end
        end
      end
      ulb_pkg::MODE_GET: begin
        if (stat_r == ulb_pkg::ST_DONE) begin
          ex_stat    = ulb_pkg::ST_IDLE;
          ex_rxon    = 1'b1;
          ex_pos     = '0;
          ex_acc     = 1'b1;
          ex_read    = 1'b1;
          ex_run     = 1'b1;
          ex_rd_addr = '0;
          // readout stops after the run limit
          if (pos_r == '0) begin
            ex_last_addr = '0;
          end else if (32'(pos_r) > ulb_pkg::MAX_RUN) begin
            ex_last_addr = AW'(ulb_pkg::MAX_RUN - 1);
          end else begin
            ex_last_addr = AW'(pos_r - 1'b1);
          end
        end
      end
      default: begin
        ex_stat = stat_r;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    bstate_nxt = bstate_r;
    case (bstate_r)
      ulb_pkg::B_IDLE: begin
        if (go && ex_read) begin
          bstate_nxt = ulb_pkg::B_READ;
        end
      end
      ulb_pkg::B_READ: begin
        bstate_nxt = ulb_pkg::B_EMIT;
      end
      ulb_pkg::B_EMIT: begin
        if (slot_free) begin
          bstate_nxt = run_end ? ulb_pkg::B_IDLE : ulb_pkg::B_READ;
        end
      end
      default: begin
        bstate_nxt = ulb_pkg::B_IDLE;
      end
    endcase
  end

  // sequencer outputs and register updates
  always_comb begin
    q_pop         = go;
    rd_en         = (bstate_r == ulb_pkg::B_READ);
    stat_nxt      = stat_r;
    rxon_nxt      = rxon_r;
    pos_nxt       = pos_r;
    lc_nxt        = lc_r;
    rd_addr_nxt   = rd_addr_r;
    last_addr_nxt = last_addr_r;
    run_nxt       = run_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    if (go) begin
      stat_nxt      = ex_stat;
      rxon_nxt      = ex_rxon;
      pos_nxt       = ex_pos;
      lc_nxt        = ex_lc;
      rd_addr_nxt   = ex_rd_addr;
      last_addr_nxt = ex_last_addr;
      run_nxt       = ex_run;
      acc_nxt       = ex_acc;
      if (!ex_read) begin
        out_valid_nxt          = 1'b1;
        out_res_nxt            = '0;
        out_res_nxt.status     = ex_stat;
        out_res_nxt.rx_enabled = ex_rxon;
        out_res_nxt.accepted   = ex_acc;
      end
    end
    if (emit_done) begin
      out_valid_nxt          = 1'b1;
      out_res_nxt            = '0;
      out_res_nxt.status     = stat_r;
      out_res_nxt.rx_enabled = rxon_r;
      out_res_nxt.accepted   = acc_r;
      if (run_r) begin
        out_res_nxt.read_valid = 1'b1;
        out_res_nxt.read_byte  = rd_data_r;
        out_res_nxt.read_last  = run_end;
        rd_addr_nxt            = rd_addr_r + 1'b1;
      end else begin
        out_res_nxt.tx_valid = 1'b1;
        out_res_nxt.tx_byte  = rd_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= ulb_pkg::B_IDLE;
      stat_r      <= ulb_pkg::ST_IDLE;
      rxon_r      <= 1'b1;
      pos_r       <= '0;
      lc_r        <= '0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bstate_r    <= bstate_nxt;
      stat_r      <= stat_nxt;
      rxon_r      <= rxon_nxt;
      pos_r       <= pos_nxt;
      lc_r        <= lc_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    last_addr_r <= last_addr_nxt;
    acc_r       <= acc_nxt;
    out_res_r   <= out_res_nxt;
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (go && ex_wr) begin
      line_mem_r[ex_wr_addr] <= q_op.data;
    end
    if (rd_en) begin
      rd_data_r <= line_mem_r[rd_addr_r];
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_res_r;

endmodule

### rtl/core/uart_line_buffer_unit.sv
`timescale 1ns / 1ps
// Half-duplex UART line buffer: one store of LINE_DEPTH bytes collects a
// received line (ended by CR, LF, NUL or a full store) or holds a send string
// that is handed out byte by byte on transmit-done requests. Requests enter a
// two-entry queue and are executed one at a time, so a request passes the
// queue and the output register on its way to its result. Requests with no
// stored byte in the result give it in the cycle after reaching the executor;
// a transmit byte passes address, store read and output register; a get
// readout reads then emits each character, up to sixteen, paced by the
// single registered read port of the line store and held by output stalls.
// The output register lets the queue keep filling while a result waits.
module uart_line_buffer_unit #(
  parameter int LINE_DEPTH = ulb_pkg::LINE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_data,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic       out_rx_enabled,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_accepted,
  output logic       out_read_valid,
  output logic [7:0] out_read_byte,
  output logic       out_read_last
);

  logic             q_valid;
  logic             q_pop;
  ulb_pkg::op_t     q_op;
  ulb_pkg::result_t res;

  ulb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_data  (in_data),
    .in_last  (in_last),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_pop    (q_pop)
  );

  ulb_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res       (res),
    .out_stall (out_stall)
  );

  // result fields onto their ports
  assign out_status     = res.status;
  assign out_rx_enabled = res.rx_enabled;
  assign out_tx_valid   = res.tx_valid;
  assign out_tx_byte    = res.tx_byte;
  assign out_accepted   = res.accepted;
  assign out_read_valid = res.read_valid;
  assign out_read_byte  = res.read_byte;
  assign out_read_last  = res.read_last;

endmodule

### rtl/core/ulb_checker.sv
`timescale 1ns / 1ps
`include "uart_line_buffer_unit_defines.svh"
module ulb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_mode,
  input logic [7:0] in_data,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic       out_rx_enabled,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_byte,
  input logic       out_accepted,
  input logic       out_read_valid,
  input logic [7:0] out_read_byte,
  input logic       out_read_last
);

  // a stalled result holds
  `ULB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_read_byte) && $stable(out_tx_byte) && $stable(out_status))

  // readout characters come only after a get, with the receiver back on
  `ULB_ASSERT_IMP(a_read_state, clk, rst_n, out_valid && out_read_valid, out_accepted && out_rx_enabled && (out_status == ulb_pkg::ST_IDLE))

  // a transmit byte is only handed over while transmitting
  `ULB_ASSERT_IMP(a_tx_state, clk, rst_n, out_valid && out_tx_valid, !out_rx_enabled && (out_status == ulb_pkg::ST_TX) && !out_read_valid)

  // end of run only marks a line character
  `ULB_ASSERT_IMP(a_last_flag, clk, rst_n, out_valid && out_read_last, out_read_valid)

endmodule

bind uart_line_buffer_unit ulb_checker u_ulb_checker (.*);
